>>> rtl/lbc_pkg.sv
// ---------------------------------------------------------------------------
// lbc_pkg
// Shared types, constants and the arctangent table of the beam converter.
// ---------------------------------------------------------------------------
package lbc_pkg;

    // Register map of the configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_ANGLE  = 3'd0,
        CFG_ANGLE_STEP   = 3'd1,
        CFG_MOUNT_ANGLE  = 3'd2,
        CFG_OFFSET_X     = 3'd3,
        CFG_OFFSET_Y     = 3'd4,
        CFG_WINDOW_LOW   = 3'd5,
        CFG_WINDOW_HIGH  = 3'd6,
        CFG_KEEP_OUTSIDE = 3'd7
    } t_cfg_idx;

    // Datapath widths of the rotation chain.
    localparam int XW = 49;   // x and y, range times 2^30 plus headroom
    localparam int ZW = 34;   // residual angle, 2^32 counts per turn
    localparam int AW = 20;   // beam angle accumulator
    localparam int OW = 18;   // output coordinates
    localparam int TABLE_LEN = 24;

    // 1/K of the rotation chain in Q30.
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    typedef struct packed {
        logic                 valid;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
        logic                 keep;
        logic                 last;
    } t_cell;

    // Arctangent of 2^-i in units of 2^32 counts per turn.
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2F9;
            15:      v = 32'h0000517C;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A2F;
            19:      v = 32'h00000517;
            20:      v = 32'h0000028B;
            21:      v = 32'h00000145;
            22:      v = 32'h000000A2;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/lbc_if.sv
// ---------------------------------------------------------------------------
// lbc_if
// Valid/ready channels for range samples in and Cartesian points out.
// ---------------------------------------------------------------------------
interface lbc_beam_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_sample;
    logic        last_beam;

    modport source (output valid, output range_sample, output last_beam, input ready);
    modport sink   (input valid, input range_sample, input last_beam, output ready);
endinterface

interface lbc_point_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] point_x;
    logic signed [17:0] point_y;
    logic               keep;
    logic               scan_end;

    modport source (output valid, output point_x, output point_y, output keep,
                    output scan_end, input ready);
    modport sink   (input valid, input point_x, input point_y, input keep,
                    input scan_end, output ready);
endinterface

>>> rtl/lidar_beam_to_cartesian.sv
// ---------------------------------------------------------------------------
// lidar_beam_to_cartesian
// Converts lidar range samples to mounted Cartesian points via CORDIC.
// ---------------------------------------------------------------------------
// Each transaction on i_beam carries one range sample and yields exactly one
// transaction on o_point after passing, in order, a register that captures
// the beam angle, one for the 1/K gain multiplication, one per CORDIC
// rotation cell, one for negation and rounding, and the output register,
// which adds the offset and saturates. The rotation cells form a pipeline
// that shifts whenever the chain advances, so a new sample can be accepted
// on every clock; the sustained rate is one transaction per cycle as long
// as o_point is drained, and the figure is set by the output register,
// which stalls the chain only when a finished point is waiting behind one
// that has not been taken. Configuration writes are expected only while no
// transaction is in flight.
module lidar_beam_to_cartesian #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lbc_beam_if.sink                             i_beam,
    lbc_point_if.source                          o_point,
    input  logic                                 i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lbc_pkg::*;

    localparam logic signed [ZW-1:0] QUARTER = $signed({{(ZW-31){1'b0}}, 31'h40000000});
    localparam logic signed [ZW-1:0] HALF    = $signed({{(ZW-32){1'b0}}, 32'h80000000});
    localparam logic signed [XW-1:0] RND     = $signed({{(XW-30){1'b0}}, 30'h20000000});
    localparam logic signed [AW:0]   ANG_MAX = 21'sd524287;
    localparam logic signed [AW:0]   ANG_MIN = -21'sd524288;
    localparam logic signed [OW+1:0] OUT_MAX = 20'sd131071;
    localparam logic signed [OW+1:0] OUT_MIN = -20'sd131072;

    // Stage that holds the captured sample and its folded angle.
    typedef struct packed {
        logic                 valid;
        logic [15:0]          range_sample;
        logic signed [ZW-1:0] z;
        logic                 neg;
        logic                 keep;
        logic                 last;
    } t_prep;

    // Stage that holds the rounded rotation result.
    typedef struct packed {
        logic                 valid;
        logic signed [XW-31:0] px;
        logic signed [XW-31:0] py;
        logic                 keep;
        logic                 last;
    } t_rnd;

    // Configuration registers.
    logic signed [AW-1:0] r_start_angle;
    logic signed [15:0]   r_angle_step;
    logic [15:0]          r_mount_angle;
    logic signed [15:0]   r_offset_x;
    logic signed [15:0]   r_offset_y;
    logic signed [AW-1:0] r_window_low;
    logic signed [AW-1:0] r_window_high;
    logic                 r_keep_outside;

    // Running beam angle.
    logic signed [AW-1:0] r_beam_angle;
    logic signed [AW-1:0] n_beam_angle;
    logic signed [AW:0]   w_angle_sum;

    // The whole chain advances together unless a finished point is blocked.
    logic w_adv;
    logic w_accept;

    t_prep r_prep;
    t_prep n_prep;
    t_cell r_first;
    t_cell w_chain [0:CORDIC_STEPS];
    t_cell n_first;
    t_rnd  r_rnd;
    t_rnd  n_rnd;

    logic [15:0]          w_phase;
    logic signed [ZW-1:0] w_z0;
    logic [45:0]          w_prod;
    logic signed [XW-1:0] w_xn;
    logic signed [XW-1:0] w_yn;
    logic signed [XW-1:0] w_xr;
    logic signed [XW-1:0] w_yr;
    logic signed [OW+1:0] w_sum_x;
    logic signed [OW+1:0] w_sum_y;

    logic                     r_out_valid;
    logic signed [OW-1:0]     r_out_x;
    logic signed [OW-1:0]     r_out_y;
    logic                     r_out_keep;
    logic                     r_out_last;
    logic                     w_out_load;

    assign w_out_load = !r_out_valid || o_point.ready;
    assign w_adv      = !(r_rnd.valid && !w_out_load);
    assign w_accept   = i_beam.valid && w_adv;
    assign i_beam.ready = w_adv;

    // Beam angle stepping saturates at the 20-bit limits; the last beam of
    // a scan restarts the angle at the start value instead.
    assign w_angle_sum = {r_beam_angle[AW-1], r_beam_angle}
                       + {{(AW+1-16){r_angle_step[15]}}, r_angle_step};

    always_comb begin
        if (i_beam.last_beam) begin
            n_beam_angle = r_start_angle;
        end else if (w_angle_sum > ANG_MAX) begin
            n_beam_angle = ANG_MAX[AW-1:0];
        end else if (w_angle_sum < ANG_MIN) begin
            n_beam_angle = ANG_MIN[AW-1:0];
        end else begin
            n_beam_angle = w_angle_sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle  <= '0;
            r_angle_step   <= '0;
            r_mount_angle  <= '0;
            r_offset_x     <= '0;
            r_offset_y     <= '0;
            r_window_low   <= ANG_MIN[AW-1:0];
            r_window_high  <= ANG_MAX[AW-1:0];
            r_keep_outside <= 1'b0;
            r_beam_angle   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_ANGLE: begin
                    // A new start angle also restarts any scan in progress.
                    r_start_angle <= i_cfg_data[AW-1:0];
                    r_beam_angle  <= i_cfg_data[AW-1:0];
                end
                CFG_ANGLE_STEP:   r_angle_step   <= i_cfg_data[15:0];
                CFG_MOUNT_ANGLE:  r_mount_angle  <= i_cfg_data[15:0];
                CFG_OFFSET_X:     r_offset_x     <= i_cfg_data[15:0];
                CFG_OFFSET_Y:     r_offset_y     <= i_cfg_data[15:0];
                CFG_WINDOW_LOW:   r_window_low   <= i_cfg_data[AW-1:0];
                CFG_WINDOW_HIGH:  r_window_high  <= i_cfg_data[AW-1:0];
                CFG_KEEP_OUTSIDE: r_keep_outside <= i_cfg_data[0];
                default: begin
                end
            endcase
        end else if (w_accept) begin
            r_beam_angle <= n_beam_angle;
        end
    end

    // Capture stage: fold the phase into plus or minus a quarter turn and
    // remember whether the result must be negated at the end.
    assign w_phase = r_beam_angle[15:0] + r_mount_angle;
    assign w_z0    = $signed({{(ZW-32){w_phase[15]}}, w_phase, 16'h0000});

    always_comb begin
        n_prep.valid        = w_accept;
        n_prep.range_sample = i_beam.range_sample;
        n_prep.last         = i_beam.last_beam;
        n_prep.keep         = ((r_beam_angle >= r_window_low) &&
                               (r_beam_angle <= r_window_high)) ^ r_keep_outside;
        if (w_z0 > QUARTER) begin
            n_prep.z   = w_z0 - HALF;
            n_prep.neg = 1'b1;
        end else if (w_z0 < -QUARTER) begin
            n_prep.z   = w_z0 + HALF;
            n_prep.neg = 1'b1;
        end else begin
            n_prep.z   = w_z0;
            n_prep.neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else if (w_adv) begin
            r_prep <= n_prep;
        end
    end

    // Gain stage: start vector is (range / K, 0) in Q30.
    assign w_prod = r_prep.range_sample * INV_GAIN_Q30;

    always_comb begin
        n_first.valid = r_prep.valid;
        n_first.x     = $signed({{(XW-46){1'b0}}, w_prod});
        n_first.y     = '0;
        n_first.z     = r_prep.z;
        n_first.neg   = r_prep.neg;
        n_first.keep  = r_prep.keep;
        n_first.last  = r_prep.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first.valid <= 1'b0;
        end else if (w_adv) begin
            r_first <= n_first;
        end
    end

    assign w_chain[0] = r_first;

    // Row of rotation cells, each one step with its own fixed shift.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        lbc_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // Rounding stage: negate for folded angles, then round to 1/256 m.
    assign w_xn = w_chain[CORDIC_STEPS].neg ? -w_chain[CORDIC_STEPS].x
                                            :  w_chain[CORDIC_STEPS].x;
    assign w_yn = w_chain[CORDIC_STEPS].neg ? -w_chain[CORDIC_STEPS].y
                                            :  w_chain[CORDIC_STEPS].y;
    assign w_xr = w_xn + RND;
    assign w_yr = w_yn + RND;

    always_comb begin
        n_rnd.valid = w_chain[CORDIC_STEPS].valid;
        n_rnd.px    = w_xr[XW-1:30];
        n_rnd.py    = w_yr[XW-1:30];
        n_rnd.keep  = w_chain[CORDIC_STEPS].keep;
        n_rnd.last  = w_chain[CORDIC_STEPS].last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd.valid <= 1'b0;
        end else if (w_adv) begin
            r_rnd <= n_rnd;
        end
    end

    // Output register: add the mounting offset and saturate to 18 bits.
    assign w_sum_x = {r_rnd.px[XW-31], r_rnd.px}
                   + {{(OW+2-16){r_offset_x[15]}}, r_offset_x};
    assign w_sum_y = {r_rnd.py[XW-31], r_rnd.py}
                   + {{(OW+2-16){r_offset_y[15]}}, r_offset_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_rnd.valid;
            if (r_rnd.valid) begin
                if (w_sum_x > OUT_MAX) begin
                    r_out_x <= OUT_MAX[OW-1:0];
                end else if (w_sum_x < OUT_MIN) begin
                    r_out_x <= OUT_MIN[OW-1:0];
                end else begin
                    r_out_x <= w_sum_x[OW-1:0];
                end
                if (w_sum_y > OUT_MAX) begin
                    r_out_y <= OUT_MAX[OW-1:0];
                end else if (w_sum_y < OUT_MIN) begin
                    r_out_y <= OUT_MIN[OW-1:0];
                end else begin
                    r_out_y <= w_sum_y[OW-1:0];
                end
                r_out_keep <= r_rnd.keep;
                r_out_last <= r_rnd.last;
            end
        end
    end

    assign o_point.valid    = r_out_valid;
    assign o_point.point_x  = r_out_x;
    assign o_point.point_y  = r_out_y;
    assign o_point.keep     = r_out_keep;
    assign o_point.scan_end = r_out_last;

`ifndef NO_ASSERTIONS
    // A start angle write restarts the beam angle at the written value.
    a_start_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_START_ANGLE)
        |=> r_beam_angle == $past(i_cfg_data[AW-1:0]))
        else $error("beam angle not restarted by start angle write");

    // After the last beam of a scan the angle is back at the start angle.
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_beam.last_beam && !i_cfg_we)
        |=> r_beam_angle == r_start_angle)
        else $error("beam angle not reset after last beam");

    // A new output point only ever comes from a valid rounding stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rnd.valid))
        else $error("output valid without a finished point");

    // A blocked finished point freezes the chain and the input.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rnd.valid && r_out_valid && !o_point.ready) |=> $stable(r_rnd))
        else $error("rounding stage changed while blocked");
`endif

endmodule

>>> rtl/lbc_cordic_cell.sv
// ---------------------------------------------------------------------------
// lbc_cordic_cell
// One rotation step of the CORDIC chain, registered, with a fixed shift.
// ---------------------------------------------------------------------------
module lbc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  lbc_pkg::t_cell i_cell,
    output lbc_pkg::t_cell o_cell
);
    import lbc_pkg::*;

    localparam logic [31:0] ATAN32 = atan_turn(STAGE);
    localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-32){1'b0}}, ATAN32});

    t_cell r_cell;
    t_cell n_cell;
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;

    // Arithmetic shift rounds towards minus infinity.
    assign w_dx = i_cell.y >>> STAGE;
    assign w_dy = i_cell.x >>> STAGE;

    always_comb begin
        n_cell = i_cell;
        if (!i_cell.z[ZW-1]) begin
            n_cell.x = i_cell.x - w_dx;
            n_cell.y = i_cell.y + w_dy;
            n_cell.z = i_cell.z - ATAN;
        end else begin
            n_cell.x = i_cell.x + w_dx;
            n_cell.y = i_cell.y - w_dy;
            n_cell.z = i_cell.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
